[rtl/ltl_pkg.sv]
package ltl_pkg;

    // Field widths
    localparam int TIME_W = 32;
    localparam int OFFS_W = 8;
    localparam int IDX_W  = 5;
    localparam int CFG_W  = 6;

    // Stream data widths, padded to whole bytes
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 56;

    // Length of the pending-leap window in seconds
    localparam logic [TIME_W-1:0] DAY_SECONDS = 32'd86400;

    // Request kinds carried on tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // One table entry as held in the table memory
    typedef struct packed {
        logic                     kind;
        logic signed [OFFS_W-1:0] offset;
        logic [TIME_W-1:0]        etime;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // One lookup result, last field in the lowest bits
    typedef struct packed {
        logic [TIME_W-1:0]        utc_from_tai;
        logic                     leap_instant;
        logic signed [OFFS_W-1:0] tai_offset;
        logic                     stall_kind;
        logic                     stall_second;
        logic                     pending_kind;
        logic                     pending_today;
        logic signed [OFFS_W-1:0] utc_offset;
    } t_result;

    // Scan control from the sequencer to the evaluator
    typedef struct packed {
        logic clear;
        logic rd_vld;
        logic fin;
    } t_scan_ctl;

endpackage

[rtl/ltl_ram.sv]
module ltl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write one word
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/ltl_seq.sv]
module ltl_seq #(
    parameter int MAX_ENTRIES = 32,
    localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_op,
    input  logic [CNT_W-1:0]   i_count,
    input  logic               i_out_free,
    output logic               o_idle,
    output logic               o_rd_en,
    output logic [AW-1:0]      o_rd_addr,
    output ltl_pkg::t_scan_ctl o_ctl
);

    import ltl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } t_seq_state;

    t_seq_state  r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;
    logic        r_rd_vld;
    logic        w_clear;
    logic        w_fin;

    // Walk the table from the newest entry down to slot zero
    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        w_clear = 1'b0;
        w_fin   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_accept && i_op == OP_QUERY) begin
                    w_clear = 1'b1;
                    if (i_count == '0) begin
                        n_state = S_FINISH;
                    end else begin
                        n_addr  = AW'(i_count - CNT_W'(1));
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_addr == '0) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr - AW'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_out_free) begin
                    w_fin   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance state; track read data returning in the cycle after each read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_rd_vld <= (r_state == S_SCAN);
        end
    end

    assign o_idle       = (r_state == S_IDLE);
    assign o_rd_en      = (r_state == S_SCAN);
    assign o_rd_addr    = r_addr;
    assign o_ctl.clear  = w_clear;
    assign o_ctl.rd_vld = r_rd_vld;
    assign o_ctl.fin    = w_fin;

endmodule

[rtl/ltl_eval.sv]
module ltl_eval (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ltl_pkg::t_scan_ctl            i_ctl,
    input  logic [ltl_pkg::TIME_W-1:0]    i_query,
    input  ltl_pkg::t_entry               i_entry,
    output ltl_pkg::t_result              o_result
);

    import ltl_pkg::*;

    logic [TIME_W-1:0]        r_q;
    logic [TIME_W-1:0]        r_q1;
    logic                     r_utc_fnd;
    logic signed [OFFS_W-1:0] r_utc_off;
    logic                     r_pend;
    logic                     r_pend_kind;
    logic                     r_stall;
    logic                     r_stall_kind;
    logic                     r_tai_fnd;
    logic signed [OFFS_W-1:0] r_tai_off;
    logic                     r_instant;
    logic [TIME_W-1:0]        r_prev_bnd;
    logic                     r_prev_vld;

    logic [TIME_W-1:0] w_day_start;
    logic [TIME_W-1:0] w_bnd;
    logic              w_utc_hit;
    logic              w_pend_hit;
    logic              w_stall_hit;
    logic              w_tai_hit;
    logic              w_next_hit;

    // Compare the entry just read against the query
    always_comb begin
        w_day_start = i_entry.etime - DAY_SECONDS;
        w_bnd       = i_entry.etime + TIME_W'(i_entry.offset);
        w_utc_hit   = (i_entry.etime <= r_q);
        w_pend_hit  = (r_q >= w_day_start) && (r_q < i_entry.etime);
        w_stall_hit = (r_q1 == i_entry.etime);
        w_tai_hit   = (w_bnd <= r_q);
        w_next_hit  = r_prev_vld && (r_prev_bnd == r_q1);
    end

    // Hold the first match of each search
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_utc_fnd  <= 1'b0;
            r_pend     <= 1'b0;
            r_stall    <= 1'b0;
            r_tai_fnd  <= 1'b0;
            r_prev_vld <= 1'b0;
        end else if (i_ctl.clear) begin
            r_utc_fnd  <= 1'b0;
            r_pend     <= 1'b0;
            r_stall    <= 1'b0;
            r_tai_fnd  <= 1'b0;
            r_prev_vld <= 1'b0;
        end else if (i_ctl.rd_vld) begin
            r_prev_vld <= 1'b1;
            if (!r_utc_fnd && w_utc_hit) begin
                r_utc_fnd <= 1'b1;
            end
            if (!r_pend && w_pend_hit) begin
                r_pend <= 1'b1;
            end
            if (!r_stall && w_stall_hit) begin
                r_stall <= 1'b1;
            end
            if (!r_tai_fnd && w_tai_hit) begin
                r_tai_fnd <= 1'b1;
            end
        end
    end

    // Capture query and matched values
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_q          <= i_query;
            r_q1         <= i_query + TIME_W'(1);
            r_utc_off    <= '0;
            r_pend_kind  <= 1'b0;
            r_stall_kind <= 1'b0;
            r_tai_off    <= '0;
            r_instant    <= 1'b0;
        end else if (i_ctl.rd_vld) begin
            r_prev_bnd <= w_bnd;
            if (!r_utc_fnd && w_utc_hit) begin
                r_utc_off <= i_entry.offset;
            end
            if (!r_pend && w_pend_hit) begin
                r_pend_kind <= i_entry.kind;
            end
            if (!r_stall && w_stall_hit) begin
                r_stall_kind <= i_entry.kind;
            end
            // the entry read just before this one is the next newer one
            if (!r_tai_fnd && w_tai_hit) begin
                r_tai_off <= i_entry.offset;
                r_instant <= w_next_hit;
            end
        end
    end

    // Without a TAI match the next entry is slot zero, the last one read
    always_comb begin
        o_result.utc_offset    = r_utc_off;
        o_result.pending_today = r_pend;
        o_result.pending_kind  = r_pend_kind;
        o_result.stall_second  = r_stall;
        o_result.stall_kind    = r_stall_kind;
        o_result.tai_offset    = r_tai_off;
        o_result.leap_instant  = r_tai_fnd ? r_instant : w_next_hit;
        o_result.utc_from_tai  = r_q - TIME_W'(r_tai_off);
    end

endmodule

[rtl/leap_second_table_lookup_top.sv]
// Channel   Direction  Ports                        Contents
// -------   ---------  ---------------------------  ----------------------------------------
// s_axis    in         tvalid tready tdata tuser    load entry or query time
// m_axis    out        tvalid tready tdata          one lookup result per query
// cfg       in         i_cfg_valid o_cfg_ready      entries_in_use
//
// A load request writes the table memory directly and leaves the block idle.
// A query with n entries in use holds off the next request while the sequencer
// passes scan (skipped when n is 0), drain and finish; the single memory read port
// reads one entry per cycle, newest first. Reset is synchronous, active low, and clears
// control only; the table is undefined until loaded. A stalled result waits in the
// output register and holds the block in its final step until m_axis_tready.
module leap_second_table_lookup_top #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // cfg: entries_in_use
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ltl_pkg::CFG_W-1:0]          i_cfg_data,
    // request stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // entry_index, entry_time, entry_offset, entry_type, query_time, zero pad
    input  logic [ltl_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // op
    input  logic                               s_axis_tuser,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // utc_offset, pending_today, pending_kind, stall_second, stall_kind,
    // tai_offset, leap_instant, utc_from_tai, zero pad
    output logic [ltl_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    import ltl_pkg::*;

    localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic [CFG_W-1:0] r_entries;
    logic [CNT_W-1:0] w_count;
    logic             w_accept;
    logic             w_idle;
    logic             w_wr_en;
    logic [IDX_W-1:0] w_idx;
    t_entry           w_wr_entry;
    t_entry           w_rd_entry;
    logic             w_rd_en;
    logic [AW-1:0]    w_rd_addr;
    t_scan_ctl        w_ctl;
    t_result          w_result;
    logic             w_out_free;
    logic             r_out_vld;
    t_result          r_out;

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_entries <= i_cfg_data;
        end
    end

    // Saturate the entry count to the table depth
    always_comb begin
        if (int'(r_entries) > MAX_ENTRIES) begin
            w_count = CNT_W'(MAX_ENTRIES);
        end else begin
            w_count = CNT_W'(r_entries);
        end
    end

    // Unpack the request
    assign s_axis_tready    = w_idle;
    assign w_accept         = s_axis_tvalid && s_axis_tready;
    assign w_idx            = s_axis_tdata[4:0];
    assign w_wr_entry.etime  = s_axis_tdata[36:5];
    assign w_wr_entry.offset = s_axis_tdata[44:37];
    assign w_wr_entry.kind   = s_axis_tdata[45];

    // Drop loads to slots beyond the table
    assign w_wr_en = w_accept && (s_axis_tuser == OP_LOAD) && (int'(w_idx) < MAX_ENTRIES);

    ltl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (AW'(w_idx)),
        .i_wr_data (w_wr_entry),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_entry)
    );

    ltl_seq #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_op       (s_axis_tuser),
        .i_count    (w_count),
        .i_out_free (w_out_free),
        .o_idle     (w_idle),
        .o_rd_en    (w_rd_en),
        .o_rd_addr  (w_rd_addr),
        .o_ctl      (w_ctl)
    );

    ltl_eval u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_query  (s_axis_tdata[77:46]),
        .i_entry  (w_rd_entry),
        .o_result (w_result)
    );

    // Output register
    assign w_out_free = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_ctl.fin) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.fin) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out);

endmodule

[dv/leap_second_table_lookup_top_tb.sv]
`timescale 1ns / 100ps

module leap_second_table_lookup_top_tb;
    import ltl_pkg::*;

    localparam int TABLE_DEPTH    = 32;
    localparam int RES_W          = $bits(t_result);
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TARGET_ITEMS   = 400;

    // One request as it travels on the input stream
    typedef struct packed {
        logic                     op;
        logic [IDX_W-1:0]         slot;
        logic [TIME_W-1:0]        etime;
        logic signed [OFFS_W-1:0] eoff;
        logic                     kind;
        logic [TIME_W-1:0]        qtime;
    } t_request;

    // Table mirror and lookup predictor; holds the results still awaited
    class lookup_scoreboard;
        logic [TIME_W-1:0] etimes[TABLE_DEPTH];
        logic [OFFS_W-1:0] offs[TABLE_DEPTH];
        logic              kinds[TABLE_DEPTH];
        int                in_use;
        t_result           awaited[$];
        int                mismatches;

        function new();
            foreach (etimes[k]) begin
                etimes[k] = '0;
                offs[k]   = '0;
                kinds[k]  = 1'b0;
            end
            in_use     = 0;
            mismatches = 0;
        endfunction

        function void write_count(logic [CFG_W-1:0] v);
            in_use = (v > TABLE_DEPTH) ? TABLE_DEPTH : int'(v);
        endfunction

        function logic [TIME_W-1:0] widen(logic [OFFS_W-1:0] o);
            return {{(TIME_W-OFFS_W){o[OFFS_W-1]}}, o};
        endfunction

        // Scan newest first for each flag and offset of a query
        function t_result predict_lookup(logic [TIME_W-1:0] q);
            t_result           r;
            bit                hit;
            int                nxt;
            logic [TIME_W-1:0] t;
            logic [TIME_W-1:0] b;
            r = '0;

            hit = 1'b0;
            for (int k = in_use - 1; k >= 0; k--) begin
                if (!hit && etimes[k] <= q) begin
                    hit = 1'b1;
                    r.utc_offset = offs[k];
                end
            end

            hit = 1'b0;
            for (int k = in_use - 1; k >= 0; k--) begin
                t = etimes[k];
                if (!hit && q >= t - DAY_SECONDS && q < t) begin
                    hit = 1'b1;
                    r.pending_today = 1'b1;
                    r.pending_kind  = kinds[k];
                end
            end

            hit = 1'b0;
            for (int k = in_use - 1; k >= 0; k--) begin
                t = etimes[k];
                if (!hit && q == t - 32'd1) begin
                    hit = 1'b1;
                    r.stall_second = 1'b1;
                    r.stall_kind   = kinds[k];
                end
            end

            // Read the query as TAI; the entry after the match decides the instant
            hit = 1'b0;
            nxt = 0;
            for (int k = in_use - 1; k >= 0; k--) begin
                b = etimes[k] + widen(offs[k]);
                if (!hit && b <= q) begin
                    hit = 1'b1;
                    nxt = k + 1;
                    r.tai_offset = offs[k];
                end
            end
            if (nxt < in_use) begin
                b = etimes[nxt] + widen(offs[nxt]);
                r.leap_instant = (b == q + 32'd1);
            end
            r.utc_from_tai = q - widen(r.tai_offset);
            return r;
        endfunction

        function void note_request(t_request req);
            if (req.op == OP_LOAD) begin
                etimes[req.slot] = req.etime;
                offs[req.slot]   = req.eoff;
                kinds[req.slot]  = req.kind;
            end else begin
                awaited.push_back(predict_lookup(req.qtime));
            end
        endfunction

        function void compare_field(string name, logic [TIME_W-1:0] want,
                                    logic [TIME_W-1:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (awaited.size() == 0) begin
                $error("result with no query outstanding: 0x%0h", got);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            compare_field("utc_offset", TIME_W'(want.utc_offset), TIME_W'(got.utc_offset));
            compare_field("pending_today", TIME_W'(want.pending_today),
                          TIME_W'(got.pending_today));
            compare_field("pending_kind", TIME_W'(want.pending_kind),
                          TIME_W'(got.pending_kind));
            compare_field("stall_second", TIME_W'(want.stall_second),
                          TIME_W'(got.stall_second));
            compare_field("stall_kind", TIME_W'(want.stall_kind), TIME_W'(got.stall_kind));
            compare_field("tai_offset", TIME_W'(want.tai_offset), TIME_W'(got.tai_offset));
            compare_field("leap_instant", TIME_W'(want.leap_instant),
                          TIME_W'(got.leap_instant));
            compare_field("utc_from_tai", want.utc_from_tai, got.utc_from_tai);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_W-1:0]       i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // entry_index, entry_time, entry_offset, entry_type, query_time, zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // op
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // utc_offset, pending_today, pending_kind, stall_second, stall_kind,
    // tai_offset, leap_instant, utc_from_tai, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    lookup_scoreboard  sb;
    logic [TIME_W-1:0] tbl_times[TABLE_DEPTH];
    logic [OFFS_W-1:0] tbl_offs[TABLE_DEPTH];
    int                active_count = 0;
    int                items_sent   = 0;
    bit                steady       = 1'b0;
    int                idle_cycles  = 0;

    leap_second_table_lookup_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 6);
    endfunction

    // Fill every field at random so unused fields toggle too
    function automatic t_request random_request();
        t_request r;
        r.op    = 1'($urandom_range(0, 1));
        r.slot  = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
        r.etime = $urandom;
        r.eoff  = OFFS_W'($urandom_range(0, 255));
        r.kind  = 1'($urandom_range(0, 1));
        r.qtime = $urandom;
        return r;
    endfunction

    // Aim most queries at the edges of a live entry
    function automatic logic [TIME_W-1:0] pick_query_time();
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] b;
        int                k;
        if (active_count == 0 || $urandom_range(0, 9) == 0)
            return $urandom;
        k = $urandom_range(0, active_count - 1);
        t = tbl_times[k];
        b = t + {{(TIME_W-OFFS_W){tbl_offs[k][OFFS_W-1]}}, tbl_offs[k]};
        case ($urandom_range(0, 10))
            0:       return t;
            1:       return t - 32'd1;
            2:       return t + 32'd1;
            3:       return t - DAY_SECONDS;
            4:       return t - DAY_SECONDS - 32'd1;
            5:       return t - DAY_SECONDS + 32'd1;
            6:       return b;
            7:       return b - 32'd1;
            8:       return b + 32'd1;
            9:       return t - $urandom_range(0, 86400);
            default: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
        endcase
    endfunction

    // Hold valid across back-to-back requests; drop it only for a gap
    task automatic send_request(t_request r);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, r.qtime, r.kind, r.eoff, r.etime, r.slot};
        s_axis_tuser  <= r.op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(r);
        items_sent++;
    endtask

    task automatic load_entry(int slot, logic [TIME_W-1:0] t, logic [OFFS_W-1:0] o,
                              logic k);
        t_request r;
        r       = random_request();
        r.op    = OP_LOAD;
        r.slot  = IDX_W'(slot);
        r.etime = t;
        r.eoff  = o;
        r.kind  = k;
        tbl_times[slot] = t;
        tbl_offs[slot]  = o;
        send_request(r);
    endtask

    task automatic query(logic [TIME_W-1:0] q);
        t_request r;
        r       = random_request();
        r.op    = OP_QUERY;
        r.qtime = q;
        send_request(r);
    endtask

    // Build a whole table and load it in shuffled slot order
    task automatic load_table(int style);
        logic [TIME_W-1:0] t[TABLE_DEPTH];
        logic [OFFS_W-1:0] o[TABLE_DEPTH];
        logic              k[TABLE_DEPTH];
        int                order[TABLE_DEPTH];
        int                j;
        int                tmp;
        logic [TIME_W-1:0] cur_t;
        logic [OFFS_W-1:0] cur_o;
        cur_t = (style == 2) ? 32'hFFFF_FFFF - $urandom_range(0, 3000000) : $urandom;
        cur_o = OFFS_W'($urandom_range(0, 255));
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            case (style)
                0: begin
                    // sparse, mostly inserts stepping the offset by one
                    cur_t += $urandom_range(86400, 32'h0400_0000);
                    k[i]  = ($urandom_range(0, 9) == 0);
                    cur_o = k[i] ? cur_o - 8'd1 : cur_o + 8'd1;
                end
                1: begin
                    // dense, overlapping pending windows and repeated times
                    cur_t += $urandom_range(0, 200000);
                    k[i]  = 1'($urandom_range(0, 1));
                    cur_o = OFFS_W'($urandom_range(0, 255));
                end
                2: begin
                    // straddle the wrap of the second counter
                    cur_t += $urandom_range(1, 200000);
                    k[i]  = 1'($urandom_range(0, 1));
                    cur_o = OFFS_W'($urandom_range(0, 255));
                end
                default: begin
                    cur_t = $urandom;
                    k[i]  = 1'($urandom_range(0, 1));
                    cur_o = OFFS_W'($urandom_range(0, 255));
                end
            endcase
            t[i]     = cur_t;
            o[i]     = cur_o;
            order[i] = i;
        end
        for (int i = TABLE_DEPTH - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < TABLE_DEPTH; i++)
            load_entry(order[i], t[order[i]], o[order[i]], k[order[i]]);
    endtask

    // Drain every awaited result, then let a trailing scan finish
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(logic [CFG_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.write_count(v);
        active_count = (v > TABLE_DEPTH) ? TABLE_DEPTH : int'(v);
    endtask

    // Result side: random stalls, check each accepted result
    initial begin
        int      stall;
        t_result got;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got = m_axis_tdata[RES_W-1:0];
            sb.check_result(got);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("leap_second_table_lookup_top_tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [CFG_W-1:0] presets[6];
        logic [CFG_W-1:0] count;
        presets = '{6'd32, 6'd63, 6'd1, 6'd33, 6'd0, 6'd17};
        sb = new();
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_LOAD;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table: everything zero, conversion passes the query through
        write_config(6'd0);
        query(32'h0);
        query(32'hFFFF_FFFF);

        // Small table with wrapping windows, boundaries and both kinds
        load_entry(0, 32'h0000_0000, 8'sd0, 1'b1);
        load_entry(1, 32'd86400, -8'sd128, 1'b0);
        load_entry(2, 32'h8000_0000, 8'sd37, 1'b1);
        load_entry(3, 32'hFFFF_FFF0, 8'sd127, 1'b0);
        wait_idle();
        write_config(6'd4);
        query(32'h0);
        query(32'hFFFF_FFFF);
        query(32'd86399);
        query(32'd86400);
        query(32'd86271);
        query(32'd86272);
        query(32'h7FFF_FFFF);
        query(32'h7FFE_AE80);
        query(32'h7FFE_AE7F);
        query(32'h8000_0024);
        query(32'h8000_0025);
        query(32'hFFFF_FFEF);
        query(32'h0000_006E);
        query(32'h0000_006F);

        // Random phases, each with its own table setting and pacing
        for (int phase = 0; items_sent < TARGET_ITEMS || phase < 6; phase++) begin
            steady = (phase == 2) || ($urandom_range(0, 3) == 0);
            if (phase == 0 || $urandom_range(0, 1) == 1)
                load_table($urandom_range(0, 3));
            wait_idle();
            count = (phase < 6) ? presets[phase] : 6'($urandom_range(0, 63));
            write_config(count);
            repeat (40) begin
                if ($urandom_range(0, 19) == 0)
                    load_entry($urandom_range(0, TABLE_DEPTH - 1), $urandom,
                               OFFS_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                else
                    query(pick_query_time());
            end
        end

        wait_idle();
        if (sb.mismatches == 0)
            $display("leap_second_table_lookup_top_tb: PASS");
        else
            $display("leap_second_table_lookup_top_tb: FAIL");
        $finish;
    end

endmodule
